// File: sv/multi_waveform_oscillator_core_macros.svh
// Assertion macros shared by the oscillator core.
`ifndef MULTI_WAVEFORM_OSCILLATOR_CORE_MACROS_SVH
`define MULTI_WAVEFORM_OSCILLATOR_CORE_MACROS_SVH

// Same-cycle implication, checked at every clk edge outside reset.
`define MWO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MWO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mwo_pkg.sv
// Types, constants and table helpers for the multi-waveform oscillator.
package mwo_pkg;

  localparam int HarmonicCountDef = 39;
  localparam int SineDepthDef     = 1024;

  localparam int FreqW   = 24;
  localparam int TimeW   = 48;
  localparam int WaveW   = 3;
  localparam int SampleW = 16;
  localparam int PhaseW  = 32;
  localparam int MagW    = 15;
  localparam int AccW    = 48;

  localparam longint          Q14One       = 16384;
  localparam longint          TwoOverPiQ24 = 10680707;
  localparam longint unsigned HalfPiQ30    = 64'd1686629713;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [AccW-1:0]    acc_t;

  typedef enum logic [WaveW-1:0] {
    WAVE_SINE        = 3'd0,
    WAVE_SQUARE      = 3'd1,
    WAVE_TRIANGLE    = 3'd2,
    WAVE_ADD_SAW     = 3'd3,
    WAVE_DIGITAL_SAW = 3'd4
  } wave_t;

  // One pipeline slot of the harmonic chain.
  typedef struct packed {
    logic              valid;
    logic [WaveW-1:0]  wave;
    logic [PhaseW-1:0] phase;
    logic [PhaseW-1:0] mphase;
    logic              neg;
    logic [MagW-1:0]   mag;
    sample_t           other;
    acc_t              acc;
  } stage_t;

  // Integer Taylor series of sin to x^15 in Q30, rounded to Q14.
  function automatic logic [MagW-1:0] quarter_sine_q14(input longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          s;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    term = ((term * x2) >> 30) / 6;   s = s - longint'(term);
    term = ((term * x2) >> 30) / 20;  s = s + longint'(term);
    term = ((term * x2) >> 30) / 42;  s = s - longint'(term);
    term = ((term * x2) >> 30) / 72;  s = s + longint'(term);
    term = ((term * x2) >> 30) / 110; s = s - longint'(term);
    term = ((term * x2) >> 30) / 156; s = s + longint'(term);
    term = ((term * x2) >> 30) / 210; s = s - longint'(term);
    if (s < 0) s = 0;
    s = (s + 32768) >>> 16;
    if (s > Q14One) s = Q14One;
    return MagW'(s);
  endfunction

endpackage

// File: sv/multi_waveform_oscillator_core.sv
// Multi-waveform oscillator core: phase product, harmonic chain, output stage.
// Stages in order: P1, stage 0, the harmonic stages, T1 and the output register.
// Throughput: one word per cycle; every stage advances together unless the
//   output register holds a word that the sink stalls.
// Each harmonic stage owns a quarter-sine ROM port, so the chain length sets latency.
// Reset (rst, synchronous) clears all valid bits; no table fill is needed.
module multi_waveform_oscillator_core #(
  parameter int HARMONIC_COUNT   = mwo_pkg::HarmonicCountDef,
  parameter int SINE_TABLE_DEPTH = mwo_pkg::SineDepthDef
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_stall,
  input  logic [mwo_pkg::FreqW-1:0]     frequency,
  input  logic [mwo_pkg::TimeW-1:0]     sample_time,
  input  logic [mwo_pkg::WaveW-1:0]     waveform,
  output logic                          sample_valid,
  input  logic                          sample_stall,
  output mwo_pkg::sample_t              sample
);
  import mwo_pkg::*;

  localparam int IdxW = $clog2(SINE_TABLE_DEPTH + 1);

  typedef logic [MagW-1:0] rom_t [0:SINE_TABLE_DEPTH];

  // Quarter-wave table, built at elaboration.
  function automatic rom_t build_rom();
    rom_t r;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      r[k] = quarter_sine_q14((64'(k) * HalfPiQ30) / SINE_TABLE_DEPTH);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  // Table address for a phase: round the quadrant offset, mirror odd quadrants.
  function automatic logic [IdxW-1:0] rom_index(input logic [PhaseW-1:0] ph);
    logic [63:0]     scaled;
    logic [IdxW-1:0] idx;
    scaled = 64'(ph[29:0]) * 64'(SINE_TABLE_DEPTH) + (64'(1) << 29);
    idx    = IdxW'(scaled >> 30);
    return ph[30] ? (IdxW'(SINE_TABLE_DEPTH) - idx) : idx;
  endfunction

  function automatic sample_t signed_sine(input stage_t s);
    sample_t m;
    m = sample_t'({1'b0, s.mag});
    return s.neg ? -m : m;
  endfunction

  // Waveforms that need no table: square, triangle, digital saw, silence.
  function automatic sample_t basic_sample(input logic [WaveW-1:0] wave,
                                           input logic [PhaseW-1:0] ph);
    logic signed [17:0] v;
    logic signed [17:0] tri_v;
    sample_t            r;
    v = 18'(ph[31:16]);
    if (ph < 32'h4000_0000)      tri_v = v;
    else if (ph < 32'hC000_0000) tri_v = 18'sd32768 - v;
    else                         tri_v = v - 18'sd65536;
    case (wave)
      WAVE_SQUARE:      r = (ph != '0 && !ph[31]) ? sample_t'(Q14One) : -sample_t'(Q14One);
      WAVE_TRIANGLE:    r = sample_t'(tri_v);
      WAVE_DIGITAL_SAW: r = sample_t'(18'(ph[31:17])) - sample_t'(Q14One);
      default:          r = '0;
    endcase
    return r;
  endfunction

  logic en;

  // The whole pipe moves as one; stall only when the output word is held.
  assign en        = !(sample_valid && sample_stall);
  assign cmd_stall = !en;

  // Stage P1: split the 24x48 product into two 24x24 partial products.
  logic              p1_valid;
  logic [WaveW-1:0]  p1_wave;
  logic [47:0]       p1_lo;
  logic [15:0]       p1_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= cmd_valid;
      p1_wave  <= waveform;
      p1_lo    <= 48'(frequency) * 48'(sample_time[23:0]);
      p1_hi    <= 16'(48'(frequency) * 48'(sample_time[47:24]));
    end
  end

  // Stage 0: fold the partial products and keep the fractional turn.
  stage_t      st [0:HARMONIC_COUNT];
  logic [39:0] frac;

  assign frac = 40'(p1_lo) + {p1_hi, 24'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else if (en) begin
      st[0].valid  <= p1_valid;
      st[0].wave   <= p1_wave;
      st[0].phase  <= frac[39:8];
      st[0].mphase <= frac[39:8];
      st[0].neg    <= 1'b0;
      st[0].mag    <= '0;
      st[0].other  <= '0;
      st[0].acc    <= '0;
    end
  end

  // Harmonic chain: stage j reads the table for harmonic j, steps the phase
  // multiple, and adds harmonic j-1 times its Fourier weight into the sum.
  // Stage 2 also hands the plain sine (harmonic one) to the other-wave slot.
  for (genvar j = 1; j <= HARMONIC_COUNT; j++) begin : g_harm
    localparam int   Kp        = (j > 1) ? (j - 1) : 1;
    localparam acc_t CoefPrev  = acc_t'((TwoOverPiQ24 + Kp / 2) / Kp);

    always_ff @(posedge clk) begin
      if (rst) begin
        st[j].valid <= 1'b0;
      end else if (en) begin
        st[j].valid  <= st[j-1].valid;
        st[j].wave   <= st[j-1].wave;
        st[j].phase  <= st[j-1].phase;
        st[j].mphase <= st[j-1].mphase + st[j-1].phase;
        st[j].neg    <= st[j-1].mphase[31];
        st[j].mag    <= SineRom[rom_index(st[j-1].mphase)];
        if (j == 1) begin
          st[j].acc   <= '0;
          st[j].other <= basic_sample(st[j-1].wave, st[j-1].phase);
        end else begin
          st[j].acc <= st[j-1].acc + acc_t'(signed_sine(st[j-1])) * CoefPrev;
          if (j == 2 && st[j-1].wave == WAVE_SINE) begin
            st[j].other <= signed_sine(st[j-1]);
          end else begin
            st[j].other <= st[j-1].other;
          end
        end
      end
    end
  end

  // Stage T1: add the last harmonic.
  localparam acc_t CoefLast = acc_t'((TwoOverPiQ24 + HARMONIC_COUNT / 2) / HARMONIC_COUNT);

  stage_t t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1.valid <= 1'b0;
    end else if (en) begin
      t1.valid  <= st[HARMONIC_COUNT].valid;
      t1.wave   <= st[HARMONIC_COUNT].wave;
      t1.phase  <= st[HARMONIC_COUNT].phase;
      t1.mphase <= st[HARMONIC_COUNT].mphase;
      t1.neg    <= st[HARMONIC_COUNT].neg;
      t1.mag    <= st[HARMONIC_COUNT].mag;
      t1.acc    <= st[HARMONIC_COUNT].acc
                   + acc_t'(signed_sine(st[HARMONIC_COUNT])) * CoefLast;
      if (HARMONIC_COUNT == 1 && st[HARMONIC_COUNT].wave == WAVE_SINE) begin
        t1.other <= signed_sine(st[HARMONIC_COUNT]);
      end else begin
        t1.other <= st[HARMONIC_COUNT].other;
      end
    end
  end

  // Output stage: round half away from zero, saturate, pick the waveform.
  acc_t    rnd;
  sample_t saw;

  always_comb begin
    if (!t1.acc[AccW-1]) begin
      rnd = (t1.acc + (acc_t'(1) <<< 23)) >>> 24;
    end else begin
      rnd = -(((-t1.acc) + (acc_t'(1) <<< 23)) >>> 24);
    end
    if (rnd > acc_t'(32767))       saw = sample_t'(32767);
    else if (rnd < acc_t'(-32768)) saw = sample_t'(-32768);
    else                           saw = sample_t'(rnd);
  end

  logic [WaveW-1:0] out_wave;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (en) begin
      sample_valid <= t1.valid;
      out_wave     <= t1.wave;
      sample       <= (t1.wave == WAVE_ADD_SAW) ? saw : t1.other;
    end
  end

`include "multi_waveform_oscillator_core_macros.svh"

  `MWO_ASSERT_NOW(a_silent_zero, sample_valid && out_wave > WAVE_DIGITAL_SAW, sample == '0, "silent code gave a nonzero sample")
  `MWO_ASSERT_NOW(a_square_level, sample_valid && out_wave == WAVE_SQUARE, sample == sample_t'(Q14One) || sample == -sample_t'(Q14One), "square sample off its two levels")
  `MWO_ASSERT_NEXT(a_tail_moves, en && t1.valid, sample_valid, "word lost between final stages")

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the multi-waveform oscillator core.
// Drives frequency/time/waveform words with random idling on both sides and
// checks every sample word against a bit-exact phase/table/harmonic predictor.

class osc_scoreboard;
  int                    errors;
  int                    seen;
  int                    matched;
  logic signed [15:0]    pending[$];
  int                    quarter[0:1024];

  function new();
    longint unsigned k;
    errors  = 0;
    seen    = 0;
    matched = 0;
    for (k = 0; k <= 1024; k++) begin
      quarter[k] = taylor_q14((k * mwo_pkg::HalfPiQ30) / 1024);
    end
  endfunction

  // Integer series of sin in Q30, rounded to Q14 and clamped.
  function int taylor_q14(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    longint unsigned k;
    x2   = (x * x) >> 30;
    term = x;
    acc  = longint'(x);
    for (k = 1; k <= 7; k++) begin
      term = (term * x2) >> 30;
      term = term / ((2 * k) * (2 * k + 1));
      if (k[0]) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    acc = (acc + 32768) >>> 16;
    if (acc > 16384) acc = 16384;
    return int'(acc);
  endfunction

  function int sine_at(logic [31:0] ph);
    longint unsigned idx;
    int              v;
    idx = ({34'd0, ph[29:0]} * 1024 + (64'd1 << 29)) >> 30;
    if (idx > 1024) idx = 1024;
    v = ph[30] ? quarter[1024 - idx] : quarter[idx];
    return ph[31] ? -v : v;
  endfunction

  function logic signed [15:0] oscillate(logic [23:0] f, logic [47:0] t, logic [2:0] w);
    logic [71:0] prod;
    logic [31:0] ph;
    logic [31:0] hp;
    longint      acc;
    longint      c;
    int          s;
    int          n;
    prod = {48'd0, f} * {24'd0, t};
    ph   = prod[39:8];
    case (w)
      mwo_pkg::WAVE_SINE: s = sine_at(ph);
      mwo_pkg::WAVE_SQUARE: s = (ph != 0 && !ph[31]) ? 16384 : -16384;
      mwo_pkg::WAVE_TRIANGLE: begin
        if (ph < 32'h4000_0000) s = int'(ph >> 16);
        else if (ph < 32'hC000_0000) s = 32768 - int'(ph >> 16);
        else s = int'(ph >> 16) - 65536;
      end
      mwo_pkg::WAVE_ADD_SAW: begin
        acc = 0;
        for (n = 1; n <= 39; n++) begin
          c  = (mwo_pkg::TwoOverPiQ24 + n / 2) / n;
          hp = ph * n;
          acc += longint'(sine_at(hp)) * c;
        end
        if (acc >= 0) acc = (acc + (64'sd1 <<< 23)) >>> 24;
        else acc = -(((-acc) + (64'sd1 <<< 23)) >>> 24);
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        s = int'(acc);
      end
      mwo_pkg::WAVE_DIGITAL_SAW: s = int'(ph >> 17) - 16384;
      default: s = 0;
    endcase
    return s[15:0];
  endfunction

  function void note_command(logic [23:0] f, logic [47:0] t, logic [2:0] w);
    pending.push_back(oscillate(f, t, w));
  endfunction

  task report(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  task check_sample(logic signed [15:0] s);
    logic signed [15:0] want;
    seen++;
    if (pending.size() == 0) begin
      report($sformatf("sample %0d with nothing outstanding", s));
      return;
    end
    want = pending.pop_front();
    if (s !== want) report($sformatf("sample word %0d: got %0d, want %0d", seen, s, want));
    else matched++;
  endtask
endclass

module testbench;
  localparam int Latency = mwo_pkg::HarmonicCountDef + 4;
  localparam int Limit   = 2000000;

  logic                clk = 0;
  logic                rst = 1;
  logic                cmd_valid = 0;
  logic                cmd_stall;
  logic [23:0]         frequency = 0;
  logic [47:0]         sample_time = 0;
  logic [2:0]          waveform = 0;
  logic                sample_valid;
  logic                sample_stall = 0;
  mwo_pkg::sample_t    sample;

  osc_scoreboard       book = new();
  int                  send_idle = 0;
  int                  recv_idle = 0;
  int                  accepted = 0;
  int                  cycles = 0;
  logic                long_hold = 0;

  multi_waveform_oscillator_core dut (
    .clk(clk), .rst(rst),
    .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
    .frequency(frequency), .sample_time(sample_time), .waveform(waveform),
    .sample_valid(sample_valid), .sample_stall(sample_stall), .sample(sample)
  );

  always #5 clk = ~clk;

  // Bound the run; a hang here means the block lost a word.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > Limit) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // Sink stall: random idling plus the long hold used to back the core up.
  always @(posedge clk) begin
    sample_stall <= long_hold || ($urandom_range(99) < recv_idle);
  end

  // Check every sample word the sink accepts.
  always @(posedge clk) begin
    if (!rst && sample_valid && !sample_stall) book.check_sample(sample);
  end

  // Hold off the sink for a long stretch once the random traffic is going.
  initial begin
    wait (accepted >= 300);
    @(posedge clk);
    long_hold <= 1;
    repeat (400) @(posedge clk);
    long_hold <= 0;
  end

  // Offer one command word and hold it until the core takes it.
  task automatic send_word(logic [23:0] f, logic [47:0] t, logic [2:0] w);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle && gap < 20) gap++;
    if (gap > 0) begin
      cmd_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid   <= 1;
    frequency   <= f;
    sample_time <= t;
    waveform    <= w;
    do @(posedge clk); while (cmd_stall);
    book.note_command(f, t, w);
    accepted++;
  endtask

  // Drop valid and wait until every outstanding sample has come back.
  task automatic drain();
    cmd_valid <= 0;
    @(posedge clk);
    while (book.pending.size() != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);
  endtask

  task automatic random_words(int count);
    logic [23:0] f;
    logic [47:0] t;
    logic [2:0]  w;
    repeat (count) begin
      case ($urandom_range(3))
        0: f = 24'($urandom_range(255));
        1: f = 24'($urandom_range(24'hFFFFFF));
        2: f = 24'($urandom_range(511) << 8);
        default: f = ($urandom_range(9) == 0) ? 24'hFFFFFF : 24'($urandom_range(65535));
      endcase
      t = 48'({$urandom, $urandom});
      if ($urandom_range(9) == 0) t = 48'({$urandom, $urandom}) & 48'h0000_00FF_FFFF;
      w = ($urandom_range(9) < 8) ? 3'($urandom_range(4)) : 3'($urandom_range(7));
      send_word(f, t, w);
    end
  endtask

  initial begin
    int w;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Zero frequency gives phase zero on every waveform, silent codes included.
    for (w = 0; w < 8; w++) send_word(24'd0, 48'hFFFF_FFFF_FFFF, 3'(w));
    // All-ones frequency and time on every waveform.
    for (w = 0; w < 8; w++) send_word(24'hFFFFFF, 48'hFFFF_FFFF_FFFF, 3'(w));
    // Quarter-turn boundaries: phase equals time shifted down by 8 at f = 1/256 Hz.
    send_word(24'd1, 48'h80_0000_0000, mwo_pkg::WAVE_SQUARE);
    send_word(24'd1, 48'h7F_FFFF_FF00, mwo_pkg::WAVE_SQUARE);
    send_word(24'd1, 48'h00_0000_0100, mwo_pkg::WAVE_SQUARE);
    send_word(24'd1, 48'h40_0000_0000, mwo_pkg::WAVE_TRIANGLE);
    send_word(24'd1, 48'hC0_0000_0000, mwo_pkg::WAVE_TRIANGLE);
    send_word(24'd1, 48'h40_0000_0000, mwo_pkg::WAVE_SINE);
    // Whole turns wrap away: 1 Hz at 5 s plus a quarter.
    send_word(24'h000100, 48'h5_4000_0000, mwo_pkg::WAVE_ADD_SAW);
    send_word(24'd1, 48'hFF_FFFF_FF00, mwo_pkg::WAVE_DIGITAL_SAW);
    send_word(24'd1, 48'h08_0000_0000, mwo_pkg::WAVE_ADD_SAW);
    drain();

    send_idle = 29; recv_idle = 56;
    random_words(470);
    drain();
    send_idle = 56; recv_idle = 29;
    random_words(470);
    send_idle = 0; recv_idle = 0;
    random_words(460);
    drain();

    $display("covered %0d command words, %0d samples matched, %0d mismatches",
             accepted, book.matched, book.errors);
    $display("all waveform codes, quarter-turn edges, zero and full-scale inputs, back-pressure");
    if (book.errors == 0 && book.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+sv
sv/mwo_pkg.sv
sv/multi_waveform_oscillator_core.sv
dv/testbench.sv
